/* rtl/efi_pkg.sv */
package efi_pkg;

	localparam int PIX_W    = 12;
	localparam int FX_W     = 32;
	localparam int STEP_W   = 31;
	localparam int CAP_W    = 10;
	localparam int CNT_W    = 11;
	localparam int PROD_W   = PIX_W + STEP_W;
	localparam int WIDE_W   = 48;
	localparam int SQ_W     = 2 * FX_W;
	localparam int FRAC_W   = 28;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	// |z|^2 escape bound: 4.0 in Q8.56
	localparam logic [SQ_W-1:0] ESC_BOUND = 64'h0400_0000_0000_0000;

	localparam logic              RST_MODE   = 1'b0;
	localparam logic [FX_W-1:0]   RST_OFFSET = 32'hE000_0000;
	localparam logic [STEP_W-1:0] RST_STEP   = 31'd1048576;
	localparam logic [FX_W-1:0]   RST_JULIA  = 32'h0000_0000;
	localparam logic [CAP_W-1:0]  RST_CAP    = 10'd100;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_OFF_RE   = 3'd1,
		REG_OFF_IM   = 3'd2,
		REG_STEP     = 3'd3,
		REG_JULIA_RE = 3'd4,
		REG_JULIA_IM = 3'd5,
		REG_CAP      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                   fractal_mode;
		logic signed [FX_W-1:0] offset_real;
		logic signed [FX_W-1:0] offset_imag;
		logic [STEP_W-1:0]      pixel_step;
		logic signed [FX_W-1:0] julia_real;
		logic signed [FX_W-1:0] julia_imag;
		logic [CAP_W-1:0]       iteration_cap;
	} cfg_t;

	typedef struct packed {
		logic signed [FX_W-1:0] cr;
		logic signed [FX_W-1:0] ci;
	} point_t;

	function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = {{(WIDE_W-FX_W+1){1'b0}}, {(FX_W-1){1'b1}}};
		lo = {{(WIDE_W-FX_W+1){1'b1}}, {(FX_W-1){1'b0}}};
		if (v > hi) begin
			return hi[FX_W-1:0];
		end else if (v < lo) begin
			return lo[FX_W-1:0];
		end else begin
			return v[FX_W-1:0];
		end
	endfunction

endpackage

/* rtl/efi_pix_if.sv */
interface efi_pix_if;
	logic                         valid;
	logic                         ready;
	logic [efi_pkg::PIX_W-1:0]    pixel_x;
	logic [efi_pkg::PIX_W-1:0]    pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

/* rtl/efi_res_if.sv */
interface efi_res_if;
	logic                         valid;
	logic                         ready;
	logic [efi_pkg::CNT_W-1:0]    iteration_count;
	logic                         escaped;

	modport source (output valid, output iteration_count, output escaped, input ready);
	modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface

/* rtl/escape_time_fractal_iterator_top.sv */
// Path: the front registers pixel * step, then the mapped c; c enters the queue; the idle
//   engine loads it; each escape test squares, then tests/updates; the result is registered.
// Per pixel: count+1 escape tests on escape, else cap+1, at most 1024, in the single
//   squaring/update loop, which waits for a free result register; mapping overlaps it.
// Reset (arst_n low, async): registers return to their reset values, pipeline, queue and
//   result register empty. No clearing pass.
module escape_time_fractal_iterator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// config port, APB style, pready tied high
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [efi_pkg::ADDR_W-1:0]   paddr,
	input  logic [efi_pkg::DATA_W-1:0]   pwdata,
	output logic [efi_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	// pixel in, result out: one transfer each per pixel
	efi_pix_if.sink                      pix,
	efi_res_if.source                    res
);

	efi_pkg::cfg_t    cfg;
	logic             push, q_full, pop, q_nonempty;
	efi_pkg::point_t  push_data, q_head;

	// register file
	efi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front: accepts pixels and maps them to c in Q4.28
	efi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix       (pix),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// short queue decouples mapping from the iteration loop
	efi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	// back: escape-time iteration and result register
	efi_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.pop        (pop),
		.res        (res)
	);

endmodule

/* rtl/efi_regs.sv */
module efi_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [efi_pkg::ADDR_W-1:0]   paddr,
	input  logic [efi_pkg::DATA_W-1:0]   pwdata,
	output logic [efi_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output efi_pkg::cfg_t                cfg
);

	efi_pkg::cfg_t      cfg_q;
	efi_pkg::reg_idx_t  idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = efi_pkg::reg_idx_t'(paddr[efi_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fractal_mode  <= efi_pkg::RST_MODE;
			cfg_q.offset_real   <= efi_pkg::RST_OFFSET;
			cfg_q.offset_imag   <= efi_pkg::RST_OFFSET;
			cfg_q.pixel_step    <= efi_pkg::RST_STEP;
			cfg_q.julia_real    <= efi_pkg::RST_JULIA;
			cfg_q.julia_imag    <= efi_pkg::RST_JULIA;
			cfg_q.iteration_cap <= efi_pkg::RST_CAP;
		end else if (wr_en) begin
			unique case (idx)
				efi_pkg::REG_MODE:     cfg_q.fractal_mode  <= pwdata[0];
				efi_pkg::REG_OFF_RE:   cfg_q.offset_real   <= pwdata;
				efi_pkg::REG_OFF_IM:   cfg_q.offset_imag   <= pwdata;
				efi_pkg::REG_STEP:     cfg_q.pixel_step    <= pwdata[efi_pkg::STEP_W-1:0];
				efi_pkg::REG_JULIA_RE: cfg_q.julia_real    <= pwdata;
				efi_pkg::REG_JULIA_IM: cfg_q.julia_imag    <= pwdata;
				efi_pkg::REG_CAP:      cfg_q.iteration_cap <= pwdata[efi_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			efi_pkg::REG_MODE:     prdata = {{(efi_pkg::DATA_W-1){1'b0}}, cfg_q.fractal_mode};
			efi_pkg::REG_OFF_RE:   prdata = cfg_q.offset_real;
			efi_pkg::REG_OFF_IM:   prdata = cfg_q.offset_imag;
			efi_pkg::REG_STEP:     prdata = {1'b0, cfg_q.pixel_step};
			efi_pkg::REG_JULIA_RE: prdata = cfg_q.julia_real;
			efi_pkg::REG_JULIA_IM: prdata = cfg_q.julia_imag;
			efi_pkg::REG_CAP:
				prdata = {{(efi_pkg::DATA_W-efi_pkg::CAP_W){1'b0}}, cfg_q.iteration_cap};
			default:               prdata = '0;
		endcase
	end

endmodule

/* rtl/efi_front.sv */
module efi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  efi_pkg::cfg_t     cfg,
	efi_pix_if.sink           pix,
	output logic              push,
	output efi_pkg::point_t   push_data,
	input  logic              q_full
);

	logic [efi_pkg::PROD_W-1:0]        px_prod_s1, py_prod_s1;
	logic                              v_s1, v_s2;
	efi_pkg::point_t                   pt_s2;
	logic                              en_s1, en_s2;
	logic signed [efi_pkg::WIDE_W-1:0] sx, sy;

	assign push      = v_s2 && !q_full;
	assign push_data = pt_s2;
	assign en_s2     = !v_s2 || push;
	assign en_s1     = !v_s1 || en_s2;
	assign pix.ready = en_s1;

	// c = pixel * step + offset, widened then saturated to Q4.28
	assign sx = $signed({{(efi_pkg::WIDE_W-efi_pkg::PROD_W){1'b0}}, px_prod_s1})
		+ $signed({{(efi_pkg::WIDE_W-efi_pkg::FX_W){cfg.offset_real[efi_pkg::FX_W-1]}},
			cfg.offset_real});
	assign sy = $signed({{(efi_pkg::WIDE_W-efi_pkg::PROD_W){1'b0}}, py_prod_s1})
		+ $signed({{(efi_pkg::WIDE_W-efi_pkg::FX_W){cfg.offset_imag[efi_pkg::FX_W-1]}},
			cfg.offset_imag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix.valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && pix.valid) begin
			px_prod_s1 <= pix.pixel_x * cfg.pixel_step;
			py_prod_s1 <= pix.pixel_y * cfg.pixel_step;
		end
		if (en_s2 && v_s1) begin
			pt_s2.cr <= efi_pkg::sat_fx(sx);
			pt_s2.ci <= efi_pkg::sat_fx(sy);
		end
	end

endmodule

/* rtl/efi_queue.sv */
module efi_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  efi_pkg::point_t   push_data,
	output logic              full,
	input  logic              pop,
	output logic              nonempty,
	output efi_pkg::point_t   head
);

	efi_pkg::point_t              mem [efi_pkg::QDEPTH];
	logic [efi_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [efi_pkg::QPTR_W:0]     cnt_q;

	assign full     = (cnt_q == (efi_pkg::QPTR_W+1)'(efi_pkg::QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem[rd_ptr_q];

	function automatic logic [efi_pkg::QPTR_W-1:0] nxt(input logic [efi_pkg::QPTR_W-1:0] p);
		if (p == efi_pkg::QPTR_W'(efi_pkg::QDEPTH - 1)) begin
			return '0;
		end else begin
			return p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= nxt(wr_ptr_q);
			if (pop)  rd_ptr_q <= nxt(rd_ptr_q);
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue pop while empty");

endmodule

/* rtl/efi_core.sv */
module efi_core (
	input  logic              clk,
	input  logic              arst_n,
	input  efi_pkg::cfg_t     cfg,
	input  logic              q_nonempty,
	input  efi_pkg::point_t   q_head,
	output logic              pop,
	efi_res_if.source         res
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_MUL  = 3'b010,
		S_CHK  = 3'b100
	} state_t;

	state_t                            state_q;
	logic signed [efi_pkg::FX_W-1:0]   zr_q, zi_q, kr_q, ki_q;
	logic [efi_pkg::CNT_W-1:0]         cnt_q;
	logic signed [efi_pkg::SQ_W-1:0]   sr_q, si_q, xp_q;
	logic                              res_valid_q, res_esc_q;
	logic [efi_pkg::CNT_W-1:0]         res_cnt_q;

	logic [efi_pkg::SQ_W-1:0]          mag_sq;
	logic                              esc_c, last_c, done_c, can_finish;
	logic signed [efi_pkg::SQ_W-1:0]   diff, nr_sh, ni_sh;
	logic signed [efi_pkg::WIDE_W-1:0] nr_w, ni_w;

	// squares are nonnegative and at most 2^62, so the unsigned sum cannot wrap
	assign mag_sq = sr_q + si_q;
	assign esc_c  = mag_sq > efi_pkg::ESC_BOUND;
	assign last_c = cnt_q == {1'b0, cfg.iteration_cap};
	assign done_c = esc_c || last_c;
	assign can_finish = !res_valid_q || res.ready;

	assign diff  = sr_q - si_q;
	assign nr_sh = diff >>> efi_pkg::FRAC_W;
	assign ni_sh = xp_q >>> (efi_pkg::FRAC_W - 1);
	assign nr_w  = nr_sh[efi_pkg::WIDE_W-1:0]
		+ {{(efi_pkg::WIDE_W-efi_pkg::FX_W){kr_q[efi_pkg::FX_W-1]}}, kr_q};
	assign ni_w  = ni_sh[efi_pkg::WIDE_W-1:0]
		+ {{(efi_pkg::WIDE_W-efi_pkg::FX_W){ki_q[efi_pkg::FX_W-1]}}, ki_q};

	assign pop = (state_q == S_IDLE) && q_nonempty;

	assign res.valid           = res_valid_q;
	assign res.iteration_count = res_cnt_q;
	assign res.escaped         = res_esc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CHK && done_c && can_finish) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (q_nonempty) state_q <= S_MUL;
				S_MUL:  state_q <= S_CHK;
				S_CHK: begin
					if (!done_c) begin
						state_q <= S_MUL;
					end else if (can_finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (q_nonempty) begin
					zr_q  <= q_head.cr;
					zi_q  <= q_head.ci;
					kr_q  <= cfg.fractal_mode ? cfg.julia_real : q_head.cr;
					ki_q  <= cfg.fractal_mode ? cfg.julia_imag : q_head.ci;
					cnt_q <= '0;
				end
			end
			S_MUL: begin
				sr_q <= zr_q * zr_q;
				si_q <= zi_q * zi_q;
				xp_q <= zr_q * zi_q;
			end
			S_CHK: begin
				if (!done_c) begin
					zr_q  <= efi_pkg::sat_fx(nr_w);
					zi_q  <= efi_pkg::sat_fx(ni_w);
					cnt_q <= cnt_q + 1'b1;
				end else if (can_finish) begin
					res_esc_q <= esc_c;
					res_cnt_q <= esc_c ? cnt_q : cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == S_IDLE) else $error("pop outside idle");
	a_cap_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_esc_q |-> res_cnt_q == {1'b0, cfg.iteration_cap} + 1'b1)
		else $error("non-escaped count is not cap plus one");
	a_esc_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_esc_q |-> res_cnt_q <= {1'b0, cfg.iteration_cap})
		else $error("escaped count beyond cap");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |-> cnt_q <= {1'b0, cfg.iteration_cap})
		else $error("iteration counter passed cap");

endmodule
